@@ rtl/core/encvel_pkg.sv @@
// encvel_pkg: shared types and constants of the encoder velocity estimator.
// Word layouts of the request and response channels, register indexes and
// arithmetic constants. No dependencies.
package encvel_pkg;

   localparam int DATA_W      = 32;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int DIR_W       = 2;
   localparam int DIVD_W      = 53;  // |dpos| * 10^6 fits in 53 bits
   localparam int RING_DEPTH_DEF = 8;

   localparam logic [19:0]           US_PER_SEC    = 20'd1000000;
   localparam logic [DATA_W-1:0]     TIMEOUT_RESET = 32'd100000;
   localparam logic [DIR_W-1:0]      DIR_RESET     = 2'b01;

   localparam logic [CSR_IDX_W-1:0]  CSR_TIMEOUT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_DIRECTION = 1'd1;

   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic [DATA_W-1:0]        time_us;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] velocity;
      logic                     sample_taken;
      logic                     timed_out;
   } rsp_word_type;

endpackage

@@ rtl/core/encoder_velocity_estimator.sv @@
// encoder_velocity_estimator: moving average of per-change encoder velocities.
// Sample ring in a synchronous memory, one shared restoring divider.
// Depends on encvel_pkg.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+----------------------
//   req     | in        | req_valid/req_stall  | position, time_us
//   rsp     | out       | rsp_valid/rsp_stall  | velocity, flags
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// One word in flight: a word without a position change goes from ST_PREP
// straight to ST_FINISH, a word with a change uses the one-bit-per-cycle
// divider if time elapsed; a non power-of-two depth adds a divider pass for the average.
// Reset is synchronous and clears the ring valid bits at once, no sweep.
// req_stall is high while a word is worked on or its response waits for the
// output register; a response held by rsp_stall does not block the next word.
module encoder_velocity_estimator
   #(parameter int RING_DEPTH = encvel_pkg::RING_DEPTH_DEF)
   (input  logic                                 clock,
    input  logic                                 reset,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  encvel_pkg::req_word_type             req_word,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output encvel_pkg::rsp_word_type             rsp_word,
    input  logic                                 csr_we,
    input  logic [encvel_pkg::CSR_IDX_W-1:0]     csr_index,
    input  logic [encvel_pkg::CSR_W-1:0]         csr_wdata);

   import encvel_pkg::*;

   localparam int  IDX_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int  SHIFT     = $clog2(RING_DEPTH);
   localparam int  SUM_W     = DATA_W + SHIFT;
   localparam bit  DEPTH_POW2 = ((RING_DEPTH & (RING_DEPTH - 1)) == 0);
   localparam logic signed [DATA_W+1:0] SAMPLE_MAX = 34'sd2147483647;
   localparam logic signed [DATA_W+1:0] SAMPLE_MIN = -34'sd2147483648;
   localparam logic [DATA_W-1:0] Q_LIMIT = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VEL_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_LOAD, ST_DIV, ST_RESULT, ST_SAMPLE, ST_AVG, ST_FINISH
   } state_type;

   // configuration
   logic [DATA_W-1:0]        timeout_ff;
   logic signed [DIR_W-1:0]  dir_ff;

   // architectural state
   logic signed [DATA_W-1:0] prev_pos_ff;
   logic [DATA_W-1:0]        prev_time_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [DATA_W-1:0] held_ff;
   logic [RING_DEPTH-1:0]    valid_ff;

   // per-word working registers
   state_type                state_ff;
   logic signed [DATA_W-1:0] pos_ff;
   logic [DATA_W-1:0]        now_ff;
   logic signed [DATA_W:0]   dpos_ff;
   logic [DATA_W-1:0]        elapsed_ff;
   logic                     timed_ff;
   logic                     changed_ff;
   logic signed [DATA_W-1:0] raw_ff;

   // divider
   logic [DIVD_W-1:0]        dividend_ff;
   logic [DATA_W-1:0]        divisor_ff;
   logic [DATA_W-1:0]        rem_ff;
   logic [DATA_W-1:0]        quo_ff;
   logic [$clog2(DATA_W)-1:0] cnt_ff;
   logic                     ovf_ff;
   logic                     neg_ff;
   logic                     pass_avg_ff;

   // memory
   logic signed [DATA_W-1:0] ring_mem [RING_DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   // response register
   logic                     rsp_valid_ff;
   rsp_word_type             rsp_word_ff;

   // combinational next values
   logic [DATA_W-1:0]        elapsed_in;
   logic [DATA_W:0]          mag_in;
   logic [DATA_W:0]          trial_in;
   logic [DATA_W-1:0]        rem_in;
   logic                     qbit_in;
   logic signed [DATA_W-1:0] raw_in;
   logic signed [DATA_W+1:0] scaled_in;
   logic signed [DATA_W-1:0] sample_in;
   logic signed [DATA_W-1:0] old_in;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  avg_tmp_in;
   logic signed [DATA_W-1:0] avg_pow2_in;
   logic [SUM_W-1:0]         sum_mag_in;
   logic [IDX_W-1:0]         idx_in;
   logic                     req_accept;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   assign elapsed_in = req_word.time_us - prev_time_ff;
   assign mag_in     = dpos_ff[DATA_W] ? (DATA_W+1)'(-dpos_ff) : (DATA_W+1)'(dpos_ff);

   // one restoring step per cycle
   assign trial_in = {rem_ff, quo_ff[DATA_W-1]};
   assign qbit_in  = (trial_in >= {1'b0, divisor_ff});
   assign rem_in   = qbit_in ? DATA_W'(trial_in - {1'b0, divisor_ff}) : trial_in[DATA_W-1:0];

   always_comb begin
      if (ovf_ff || quo_ff > Q_LIMIT) begin
         raw_in = neg_ff ? VEL_MIN : VEL_MAX;
      end else if (neg_ff) begin
         raw_in = -$signed(quo_ff);
      end else begin
         raw_in = quo_ff[DATA_W-1] ? VEL_MAX : $signed(quo_ff);
      end
   end

   always_comb begin
      scaled_in = (DATA_W+2)'(raw_ff) * (DATA_W+2)'(dir_ff);
      if (scaled_in > SAMPLE_MAX) begin
         sample_in = VEL_MAX;
      end else if (scaled_in < SAMPLE_MIN) begin
         sample_in = VEL_MIN;
      end else begin
         sample_in = scaled_in[DATA_W-1:0];
      end
   end

   assign old_in      = valid_ff[idx_ff] ? rdata_ff : '0;
   assign sum_in      = sum_ff - SUM_W'(old_in) + SUM_W'(sample_in);
   assign idx_in      = (idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
   // truncate toward zero: bias negative sums before the arithmetic shift
   assign avg_tmp_in  = sum_ff + (sum_ff[SUM_W-1] ? SUM_W'(RING_DEPTH - 1) : SUM_W'(0));
   assign avg_pow2_in = DATA_W'(avg_tmp_in >>> SHIFT);
   assign sum_mag_in  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // sample ring: synchronous read at the current slot, write on a new sample
   always_ff @(posedge clock) begin
      rdata_ff <= ring_mem[idx_ff];
      if (state_ff == ST_SAMPLE) begin
         ring_mem[idx_ff] <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         dir_ff       <= DIR_RESET;
         prev_pos_ff  <= '0;
         prev_time_ff <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         held_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT:   timeout_ff <= csr_wdata[DATA_W-1:0];
               CSR_DIRECTION: dir_ff     <= csr_wdata[DIR_W-1:0];
               default: ;
            endcase
         end

         // ST_FINISH reloads the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  pos_ff     <= req_word.position;
                  now_ff     <= req_word.time_us;
                  dpos_ff    <= (DATA_W+1)'(req_word.position) - (DATA_W+1)'(prev_pos_ff);
                  elapsed_ff <= elapsed_in;
                  timed_ff   <= (elapsed_in > timeout_ff);
                  changed_ff <= (req_word.position != prev_pos_ff);
                  if (elapsed_in > timeout_ff) begin
                     held_ff <= '0;
                  end
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               if (!changed_ff) begin
                  state_ff <= ST_FINISH;
               end else if (elapsed_ff == '0) begin
                  raw_ff   <= dpos_ff[DATA_W] ? VEL_MIN : VEL_MAX;
                  state_ff <= ST_SAMPLE;
               end else begin
                  dividend_ff <= DIVD_W'(mag_in) * DIVD_W'(US_PER_SEC);
                  divisor_ff  <= elapsed_ff;
                  neg_ff      <= dpos_ff[DATA_W];
                  pass_avg_ff <= 1'b0;
                  state_ff    <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               // quotient of 2^32 or more only needs the high part compared
               rem_ff <= DATA_W'(dividend_ff[DIVD_W-1:DATA_W]);
               quo_ff <= dividend_ff[DATA_W-1:0];
               cnt_ff <= '0;
               if (DATA_W'(dividend_ff[DIVD_W-1:DATA_W]) >= divisor_ff) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= ST_RESULT;
               end else begin
                  ovf_ff   <= 1'b0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[DATA_W-2:0], qbit_in};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '1) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (pass_avg_ff) begin
                  held_ff  <= neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
                  state_ff <= ST_FINISH;
               end else begin
                  raw_ff   <= raw_in;
                  state_ff <= ST_SAMPLE;
               end
            end
            ST_SAMPLE: begin
               valid_ff[idx_ff] <= 1'b1;
               sum_ff           <= sum_in;
               idx_ff           <= idx_in;
               prev_pos_ff      <= pos_ff;
               prev_time_ff     <= now_ff;
               state_ff         <= ST_AVG;
            end
            ST_AVG: begin
               if (DEPTH_POW2) begin
                  held_ff  <= avg_pow2_in;
                  state_ff <= ST_FINISH;
               end else begin
                  dividend_ff <= DIVD_W'(sum_mag_in);
                  divisor_ff  <= DATA_W'(RING_DEPTH);
                  neg_ff      <= sum_ff[SUM_W-1];
                  pass_avg_ff <= 1'b1;
                  state_ff    <= ST_LOAD;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_word_ff.velocity      <= held_ff;
                  rsp_word_ff.sample_taken  <= changed_ff;
                  rsp_word_ff.timed_out     <= timed_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   // restoring divider invariant: partial remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAMPLE) |=> valid_ff[$past(idx_ff)])
      else $error("written ring slot not marked valid");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(RING_DEPTH - 1))
      else $error("ring index out of range");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP && timed_ff && !changed_ff) |-> (held_ff == '0))
      else $error("velocity not cleared on timeout");

   a_sample_needs_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAMPLE) |-> changed_ff)
      else $error("sample stored without a position change");
`endif

endmodule
